>>> rtl/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared constants, types and helper functions for the wait-for graph
// cycle detector.
// ----------------------------------------------------------------------------
package wfg_pkg;

    // Graph size and derived widths.
    localparam int MAX_NODES   = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = NODE_W + 1;

    // Input word layout: row_index, then row_bits, padded to whole bytes.
    localparam int IN_FIELDS_W = NODE_W + MAX_NODES;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    // Depth of the queue between the front and the walker.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);

    // Reset value of the process count register.
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_NODES);

    // One decoded input word as it waits in the queue.
    typedef struct packed {
        logic                 last;
        logic [MAX_NODES-1:0] bits;
        logic [NODE_W-1:0]    idx;
    } t_row_item;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [NODE_W-1:0] first_set(input logic [MAX_NODES-1:0] v);
        logic [NODE_W-1:0] r;
        r = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = NODE_W'(i);
            end
        end
        return r;
    endfunction

    // Mask with every bit below k set.
    function automatic logic [MAX_NODES-1:0] low_mask(input logic [CNT_W-1:0] k);
        logic [MAX_NODES-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            m[i] = (CNT_W'(i) < k);
        end
        return m;
    endfunction

endpackage

>>> rtl/wfg_front.sv
// ----------------------------------------------------------------------------
// wfg_front
// Accepts input words, splits them into row items and holds them in a
// short queue until the walker takes them.
// ----------------------------------------------------------------------------
module wfg_front import wfg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_last,
    output logic                 o_item_valid,
    output t_row_item            o_item,
    input  logic                 i_item_pop
);

    t_row_item          r_mem [QUEUE_DEPTH];
    logic [QUEUE_W-1:0] r_wr_ptr;
    logic [QUEUE_W-1:0] r_rd_ptr;
    logic [QUEUE_W:0]   r_count;
    logic               push;
    t_row_item          in_item;

    // Decode the incoming word into its fields.
    always_comb begin
        in_item.idx  = i_data[NODE_W-1:0];
        in_item.bits = i_data[NODE_W +: MAX_NODES];
        in_item.last = i_last;
    end

    assign o_ready      = (r_count != (QUEUE_W + 1)'(QUEUE_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    // Queue storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_item_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_item_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // The fill count never passes the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_W + 1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // The walker never takes from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

>>> rtl/wfg_walker.sv
// ----------------------------------------------------------------------------
// wfg_walker
// Stores adjacency rows and, after the last row, runs a depth-first walk
// with visited and on-path marks, one edge step per cycle. Holds the
// result in an output register.
// ----------------------------------------------------------------------------
module wfg_walker import wfg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_item_valid,
    input  t_row_item        i_item,
    output logic             o_item_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_found
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(MAX_NODES);

    logic [MAX_NODES-1:0] r_adj      [MAX_NODES];
    logic [NODE_W-1:0]    r_stk_node [MAX_NODES];
    logic [CNT_W-1:0]     r_stk_col  [MAX_NODES];
    logic [MAX_NODES-1:0] r_visited;
    logic [MAX_NODES-1:0] r_on_path;
    logic [CNT_W-1:0]     r_depth;
    logic [1:0]           r_state;
    logic                 r_found;
    logic                 r_out_valid;
    logic                 r_out_found;

    logic [CNT_W-1:0]     n_eff;
    logic [MAX_NODES-1:0] node_mask;
    logic [NODE_W-1:0]    top_idx;
    logic [NODE_W-1:0]    top_node;
    logic [CNT_W-1:0]     top_col;
    logic [MAX_NODES-1:0] cand;
    logic                 hit;
    logic [NODE_W-1:0]    next_node;
    logic [MAX_NODES-1:0] unvisited;
    logic [NODE_W-1:0]    start_node;
    logic                 out_load;

    // Active node range and the next edge out of the top of the stack.
    always_comb begin
        n_eff      = (i_count > DEPTH_MAX) ? DEPTH_MAX : i_count;
        node_mask  = low_mask(n_eff);
        top_idx    = r_depth[NODE_W-1:0] - 1'b1;
        top_node   = r_stk_node[top_idx];
        top_col    = r_stk_col[top_idx];
        cand       = r_adj[top_node] & node_mask & ~low_mask(top_col);
        hit        = |cand;
        next_node  = first_set(cand);
        unvisited  = node_mask & ~r_visited;
        start_node = first_set(unvisited);
    end

    assign o_item_pop = (r_state == ST_IDLE) && i_item_valid;
    assign out_load   = (r_state == ST_RESULT) && (!r_out_valid || i_ready);
    assign o_valid    = r_out_valid;
    assign o_found    = r_out_found;

    // Row store and walk stack contents.
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_adj[i_item.idx] <= i_item.bits;
        end
        if ((r_state == ST_START) && (unvisited != '0)) begin
            r_stk_node[0] <= start_node;
            r_stk_col[0]  <= '0;
        end
        if ((r_state == ST_WALK) && hit) begin
            r_stk_col[top_idx] <= {1'b0, next_node} + CNT_W'(1);
            if (!r_on_path[next_node] && !r_visited[next_node] && (r_depth < DEPTH_MAX)) begin
                r_stk_node[r_depth[NODE_W-1:0]] <= next_node;
                r_stk_col[r_depth[NODE_W-1:0]]  <= '0;
            end
        end
    end

    // Walk sequencer and marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_visited <= '0;
            r_on_path <= '0;
            r_depth   <= '0;
            r_found   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_item_pop && i_item.last) begin
                        r_visited <= '0;
                        r_on_path <= '0;
                        r_depth   <= '0;
                        r_state   <= ST_START;
                    end
                end
                ST_START: begin
                    if (unvisited == '0) begin
                        r_found <= 1'b0;
                        r_state <= ST_RESULT;
                    end else begin
                        r_visited[start_node] <= 1'b1;
                        r_on_path[start_node] <= 1'b1;
                        r_depth               <= CNT_W'(1);
                        r_state               <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (hit) begin
                        if (r_on_path[next_node]) begin
                            r_found <= 1'b1;
                            r_state <= ST_RESULT;
                        end else if (!r_visited[next_node] && (r_depth < DEPTH_MAX)) begin
                            r_visited[next_node] <= 1'b1;
                            r_on_path[next_node] <= 1'b1;
                            r_depth              <= r_depth + 1'b1;
                        end
                    end else begin
                        // Every edge of the top node is done: back out of it.
                        r_on_path[top_node] <= 1'b0;
                        r_depth             <= r_depth - 1'b1;
                        if (r_depth == CNT_W'(1)) begin
                            r_state <= ST_START;
                        end
                    end
                end
                ST_RESULT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= r_found;
        end
    end

    // A node on the current path is always marked visited.
    a_path_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_on_path & ~r_visited) == '0)
        else $error("on-path node not visited");

    // The walk never steps with an empty stack.
    a_walk_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_depth != '0) && (r_depth <= DEPTH_MAX))
        else $error("walk with bad stack depth");

    // The number of on-path nodes equals the stack depth during a walk.
    a_path_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ($countones(r_on_path) == 32'(r_depth)))
        else $error("path marks disagree with stack depth");

    // No row is taken while a check is running.
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_item_pop)
        else $error("row taken during a check");

endmodule

>>> rtl/wait_for_graph_cycle_detect_unit.sv
// ----------------------------------------------------------------------------
// A row word is written into the queue when it is accepted and is stored by
// the walker when popped; rows flow at one word per cycle while the walker is
// idle. A check after the last row walks the edges among the active nodes;
// the walker does one edge step, push or pop per cycle and accepts no row
// meanwhile.
// Reset (synchronous, active low) empties the queue, clears the marks and
// the result, and sets the process count to 16; stored rows are kept.
// ----------------------------------------------------------------------------
// wait_for_graph_cycle_detect_unit
// Deadlock detector: loads wait-for rows and reports whether the graph of
// the active processes holds a cycle.
// ----------------------------------------------------------------------------
module wait_for_graph_cycle_detect_unit import wfg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Row words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // row_index[3:0], row_bits[19:4], zero pad
    input  logic                  s_axis_tlast,   // last_row
    // Result words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // deadlock_found[0], zero pad
    // Process count register.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CNT_W-1:0]      i_cfg_data
);

    logic [CNT_W-1:0] r_count;
    logic             item_valid;
    t_row_item        item;
    logic             item_pop;
    logic             found;

    // Process count register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // Front: accept and queue rows.
    wfg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    // Back: store rows and walk the graph.
    wfg_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_count      (r_count),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_found      (found)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - 1){1'b0}}, found};

endmodule
